// ----- design/tac_pkg.sv -----
package tac_pkg;

  typedef enum logic [1:0] {
    MODE_MAIN   = 2'd0,
    MODE_CONFIG = 2'd1,
    MODE_ALARM  = 2'd2
  } mode_t;

  localparam logic [7:0] SPAN_RESET   = 8'd150;
  localparam logic [7:0] THRESH_RESET = 8'd100;
  localparam logic [1:0] MAX_DIGITS   = 2'd3;

  // Full-scale converter reading.
  localparam logic [10:0] ADC_FULL = 11'd1023;

  localparam logic [7:0] KEY_CONFIG = 8'h43;
  localparam logic [7:0] KEY_TOGGLE = 8'h54;
  localparam logic [7:0] KEY_STOP   = 8'h53;
  localparam logic [7:0] KEY_OK     = 8'h4F;
  localparam logic [7:0] KEY_ZERO   = 8'h30;
  localparam logic [7:0] KEY_NINE   = 8'h39;

  typedef struct packed {
    mode_t      mode;
    logic       enabled;
    logic [7:0] temp;
    logic [7:0] thresh;
    logic [7:0] entry_value;
    logic [1:0] entry_count;
  } state_t;

  typedef struct packed {
    logic        action;
    logic [17:0] prod;
    logic [7:0]  key_char;
  } item_t;

  typedef struct packed {
    logic       temp_changed;
    logic       threshold_saved;
    logic       digit_echo;
    logic [3:0] digit_value;
    logic [1:0] digit_position;
  } flags_t;

endpackage

// ----- design/temperature_alarm_controller_unit.sv -----
// Channel | Direction | Beat contents
// in_     | slave     | tuser: action; tdata: adc_sample, key_char
// out_    | master    | tdata: mode, alarm_enabled, current_temp, threshold, flags
// cfg_    | slave     | data: temp_span
//
// One beat is accepted every cycle while in_tready is high.
// The multiply by the span sits before the input register, the division and the
// mode update between the input register and the output register.
// Reset is synchronous and active low and restores span, mode, arming and threshold.
// A stalled output holds its beat; the input stage fills behind it and then drops in_tready.
module temperature_alarm_controller_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // adc_sample[9:0], key_char[17:10], zero fill
  input  logic        in_tuser,   // action
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // mode[1:0], alarm_enabled[2], current_temp[10:3],
                                  // threshold[18:11], buzzer_request[19],
                                  // temp_changed[20], threshold_saved[21],
                                  // digit_echo[22], digit_value[26:23],
                                  // digit_position[28:27], zero fill
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data
);

  logic [7:0]      span_r;
  tac_pkg::state_t state_r;
  tac_pkg::state_t state_nxt;
  tac_pkg::item_t  item_r;
  tac_pkg::flags_t flags;
  logic            s1_valid_r;
  logic            out_valid_r;
  logic [31:0]     out_data_r;
  logic            advance;

  assign cfg_ready  = 1'b1;
  assign advance    = !out_valid_r || out_tready;
  assign in_tready  = !s1_valid_r || advance;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  tac_step u_step (
    .st    (state_r),
    .item  (item_r),
    .nxt   (state_nxt),
    .flags (flags)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      span_r <= tac_pkg::SPAN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      span_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.mode        <= tac_pkg::MODE_MAIN;
      state_r.enabled     <= 1'b1;
      state_r.temp        <= 8'd0;
      state_r.thresh      <= tac_pkg::THRESH_RESET;
      state_r.entry_value <= 8'd0;
      state_r.entry_count <= 2'd0;
    end else if (s1_valid_r && advance) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r.action   <= in_tuser;
      item_r.prod     <= {8'd0, in_tdata[9:0]} * {10'd0, span_r};
      item_r.key_char <= in_tdata[17:10];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r && advance) begin
      out_data_r <= {3'b000, flags.digit_position, flags.digit_value, flags.digit_echo,
                     flags.threshold_saved, flags.temp_changed,
                     (state_nxt.mode == tac_pkg::MODE_ALARM),
                     state_nxt.thresh, state_nxt.temp, state_nxt.enabled,
                     state_nxt.mode};
    end
  end

  a_buzzer_follows_mode: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r[19] == (out_data_r[1:0] == tac_pkg::MODE_ALARM)))
    else $error("buzzer request disagrees with mode");

  a_echo_in_config: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r[22]) |-> (out_data_r[1:0] == tac_pkg::MODE_CONFIG))
    else $error("digit accepted outside config mode");

  a_single_event: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_data_r[21] && out_data_r[22]) && !(out_data_r[20] && out_data_r[22]))
    else $error("conflicting result flags");

  a_state_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && !(s1_valid_r && advance)) |=> $stable(state_r))
    else $error("state changed without an item");

  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (s1_valid_r && out_valid_r && !out_tready))
    else $error("input stalled with room in the pipeline");

endmodule

// ----- design/tac_step.sv -----
module tac_step (
  input  tac_pkg::state_t st,
  input  tac_pkg::item_t  item,
  output tac_pkg::state_t nxt,
  output tac_pkg::flags_t flags
);

  logic [10:0] fold_sum;
  logic        fold_carry;
  logic [7:0]  temp_new;
  logic [7:0]  digit8;
  logic        is_digit;
  logic        run_check;

  // The product is 1024*hi + lo, which equals 1023*hi + (hi + lo), and hi + lo
  // stays below twice the divisor, so one compare finishes the division.
  assign fold_sum   = {3'b000, item.prod[17:10]} + {1'b0, item.prod[9:0]};
  assign fold_carry = (fold_sum >= tac_pkg::ADC_FULL);
  assign temp_new   = item.prod[17:10] + {7'd0, fold_carry};
  assign digit8     = item.key_char - tac_pkg::KEY_ZERO;
  assign is_digit   = (item.key_char >= tac_pkg::KEY_ZERO) &&
                      (item.key_char <= tac_pkg::KEY_NINE);

  always_comb begin
    nxt       = st;
    flags     = '0;
    run_check = 1'b0;
    if (!item.action) begin
      if (temp_new != st.temp) begin
        nxt.temp           = temp_new;
        flags.temp_changed = 1'b1;
        run_check          = 1'b1;
      end
    end else begin
      unique case (st.mode)
        tac_pkg::MODE_MAIN: begin
          if (item.key_char == tac_pkg::KEY_CONFIG) begin
            nxt.mode        = tac_pkg::MODE_CONFIG;
            nxt.entry_value = 8'd0;
            nxt.entry_count = 2'd0;
          end else if (item.key_char == tac_pkg::KEY_TOGGLE) begin
            nxt.enabled = ~st.enabled;
            run_check   = 1'b1;
          end
        end
        tac_pkg::MODE_ALARM: begin
          if (item.key_char == tac_pkg::KEY_STOP) begin
            nxt.enabled = 1'b0;
            run_check   = 1'b1;
          end
        end
        tac_pkg::MODE_CONFIG: begin
          if (item.key_char == tac_pkg::KEY_OK) begin
            nxt.thresh            = st.entry_value;
            nxt.mode              = tac_pkg::MODE_MAIN;
            flags.threshold_saved = 1'b1;
            run_check             = 1'b1;
          end else if (item.key_char == tac_pkg::KEY_CONFIG) begin
            nxt.mode = tac_pkg::MODE_MAIN;
          end else if (is_digit && (st.entry_count < tac_pkg::MAX_DIGITS)) begin
            flags.digit_echo     = 1'b1;
            flags.digit_value    = digit8[3:0];
            flags.digit_position = st.entry_count;
            nxt.entry_count      = st.entry_count + 2'd1;
            nxt.entry_value      = (st.entry_value << 3) + (st.entry_value << 1) +
                                   {4'd0, digit8[3:0]};
          end
        end
        default: begin
        end
      endcase
    end
    if (run_check) begin
      if (nxt.enabled && (nxt.temp >= nxt.thresh)) begin
        nxt.mode = tac_pkg::MODE_ALARM;
      end else if (nxt.mode == tac_pkg::MODE_ALARM) begin
        nxt.mode = tac_pkg::MODE_MAIN;
      end
    end
  end

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

  localparam int NDIR    = 28;
  localparam int LIMIT   = 200000;
  localparam int HOLD    = 200;
  localparam int PHASES  = 6;
  localparam int PER_RUN = 80;

  localparam logic [7:0] KEY_UNUSED_E = 8'h45;
  localparam logic [7:0] KEY_UNUSED_D = 8'h44;

  typedef struct packed {
    logic [2:0]     pad;
    logic [1:0]     digit_position;
    logic [3:0]     digit_value;
    logic           digit_echo;
    logic           threshold_saved;
    logic           temp_changed;
    logic           buzzer_request;
    logic [7:0]     threshold;
    logic [7:0]     current_temp;
    logic           alarm_enabled;
    tac_pkg::mode_t mode;
  } status_t;

  typedef struct packed {
    logic       act;
    logic [9:0] smp;
    logic [7:0] key;
    logic       typed;
    status_t    want;
  } dir_row_t;

  localparam status_t NO_WANT = '0;
  localparam status_t EXP_RESET = '{pad: 3'd0, digit_position: 2'd0, digit_value: 4'd0,
                                    digit_echo: 1'b0, threshold_saved: 1'b0,
                                    temp_changed: 1'b0, buzzer_request: 1'b0,
                                    threshold: tac_pkg::THRESH_RESET, current_temp: 8'd0,
                                    alarm_enabled: 1'b1, mode: tac_pkg::MODE_MAIN};
  localparam status_t EXP_FULL = '{pad: 3'd0, digit_position: 2'd0, digit_value: 4'd0,
                                   digit_echo: 1'b0, threshold_saved: 1'b0,
                                   temp_changed: 1'b1, buzzer_request: 1'b1,
                                   threshold: tac_pkg::THRESH_RESET, current_temp: 8'd150,
                                   alarm_enabled: 1'b1, mode: tac_pkg::MODE_ALARM};

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;
  logic        in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [7:0]  cfg_data;

  logic        beat_typed;
  status_t     beat_want;

  tac_pkg::mode_t m_mode;
  logic        m_enabled;
  logic [7:0]  m_temp;
  logic [7:0]  m_thresh;
  logic [7:0]  m_entry;
  logic [1:0]  m_count;
  logic [7:0]  m_span;

  status_t     status_q [$];
  dir_row_t    directed [NDIR];

  int          errors;
  int          checked;
  int          beats;
  int          alarm_beats;
  int          spans_used;
  int          cycles;
  int          in_idle_pct;
  int          out_idle_pct;
  logic        want_hold;
  logic        hold_done;
  logic [9:0]  last_smp;

  temperature_alarm_controller_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void update_alarm();
    if (m_enabled && m_temp >= m_thresh) begin
      m_mode = tac_pkg::MODE_ALARM;
    end else if (m_mode == tac_pkg::MODE_ALARM) begin
      m_mode = tac_pkg::MODE_MAIN;
    end
  endfunction

  function automatic status_t next_status(input logic act, input logic [9:0] smp,
                                          input logic [7:0] key);
    status_t     s;
    logic [17:0] prod;
    logic [7:0]  deg;
    s = '0;
    if (!act) begin
      prod = 18'(smp) * 18'(m_span);
      deg = 8'(prod / tac_pkg::ADC_FULL);
      if (deg != m_temp) begin
        m_temp = deg;
        s.temp_changed = 1'b1;
        update_alarm();
      end
    end else begin
      case (m_mode)
        tac_pkg::MODE_MAIN: begin
          if (key == tac_pkg::KEY_CONFIG) begin
            m_mode = tac_pkg::MODE_CONFIG;
            m_count = 2'd0;
            m_entry = 8'd0;
          end else if (key == tac_pkg::KEY_TOGGLE) begin
            m_enabled = !m_enabled;
            update_alarm();
          end
        end
        tac_pkg::MODE_ALARM: begin
          if (key == tac_pkg::KEY_STOP) begin
            m_enabled = 1'b0;
            update_alarm();
          end
        end
        tac_pkg::MODE_CONFIG: begin
          if (key == tac_pkg::KEY_OK) begin
            m_thresh = m_entry;
            s.threshold_saved = 1'b1;
            m_mode = tac_pkg::MODE_MAIN;
            update_alarm();
          end else if (key == tac_pkg::KEY_CONFIG) begin
            m_mode = tac_pkg::MODE_MAIN;
          end else if (key >= tac_pkg::KEY_ZERO && key <= tac_pkg::KEY_NINE &&
                       m_count < tac_pkg::MAX_DIGITS) begin
            s.digit_value = 4'(key - tac_pkg::KEY_ZERO);
            s.digit_position = m_count;
            s.digit_echo = 1'b1;
            m_count = m_count + 2'd1;
            m_entry = m_entry * 8'd10 + 8'(s.digit_value);
          end
        end
        default: ;
      endcase
    end
    s.mode = m_mode;
    s.alarm_enabled = m_enabled;
    s.current_temp = m_temp;
    s.threshold = m_thresh;
    s.buzzer_request = (m_mode == tac_pkg::MODE_ALARM);
    return s;
  endfunction

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    status_t got;
    status_t want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got = status_t'(out_tdata);
        if (status_q.size() == 0) begin
          $display("%0t: result beat with nothing expected, expected none, actual %h",
                   $time, out_tdata);
          errors++;
        end else begin
          want = status_q.pop_front();
          check_field("mode", want.mode, got.mode);
          check_field("alarm_enabled", want.alarm_enabled, got.alarm_enabled);
          check_field("current_temp", want.current_temp, got.current_temp);
          check_field("threshold", want.threshold, got.threshold);
          check_field("buzzer_request", want.buzzer_request, got.buzzer_request);
          check_field("temp_changed", want.temp_changed, got.temp_changed);
          check_field("threshold_saved", want.threshold_saved, got.threshold_saved);
          check_field("digit_echo", want.digit_echo, got.digit_echo);
          check_field("digit_value", want.digit_value, got.digit_value);
          check_field("digit_position", want.digit_position, got.digit_position);
          checked++;
          if (got.buzzer_request) begin
            alarm_beats++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        m_span = cfg_data;
      end
      if (in_tvalid && in_tready) begin
        want = next_status(in_tuser, in_tdata[9:0], in_tdata[17:10]);
        if (beat_typed) begin
          want = beat_want;
        end
        status_q.push_back(want);
        beats++;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, status_q.size());
      $display("testbench failed");
      $finish;
    end
  end

  initial begin
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (want_hold && !hold_done) begin
        out_tready <= 1'b0;
        repeat (HOLD) @(posedge clk);
        hold_done = 1'b1;
      end
      out_tready <= ($urandom_range(99) >= out_idle_pct);
    end
  end

  task automatic send_beat(input logic act, input logic [9:0] smp, input logic [7:0] key,
                           input logic typed, input status_t want);
    while ($urandom_range(99) < in_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= act;
    in_tdata <= {6'd0, key, smp};
    beat_typed <= typed;
    beat_want <= want;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic send_key(input logic [7:0] key);
    send_beat(1'b1, 10'($urandom_range(1023)), key, 1'b0, NO_WANT);
  endtask

  task automatic send_sample(input logic [9:0] smp);
    last_smp = smp;
    send_beat(1'b0, smp, 8'($urandom_range(255)), 1'b0, NO_WANT);
  endtask

  task automatic write_span(input logic [7:0] span);
    cfg_valid <= 1'b1;
    cfg_data <= span;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    spans_used++;
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (status_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic send_random(input int count);
    int sent;
    int pick;
    int ndig;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(99);
      if (pick < 30) begin
        send_key(tac_pkg::KEY_CONFIG);
        ndig = $urandom_range(4);
        sent += ndig + 2;
        repeat (ndig) begin
          if ($urandom_range(9) == 0) begin
            send_key(8'($urandom_range(255)));
          end
          send_key(tac_pkg::KEY_ZERO + 8'($urandom_range(9)));
        end
        pick = $urandom_range(99);
        if (pick < 70) begin
          send_key(tac_pkg::KEY_OK);
        end else if (pick < 95) begin
          send_key(tac_pkg::KEY_CONFIG);
        end
      end else if (pick < 55) begin
        if ($urandom_range(6) == 0) begin
          send_sample(last_smp);
        end else begin
          send_sample(10'($urandom_range(1023)));
        end
        sent++;
      end else if (pick < 65) begin
        send_key(tac_pkg::KEY_TOGGLE);
        sent++;
      end else if (pick < 75) begin
        send_key(tac_pkg::KEY_STOP);
        sent++;
      end else if (pick < 85) begin
        send_key(8'($urandom_range(255)));
        sent++;
      end else begin
        case ($urandom_range(6))
          0: send_key(KEY_UNUSED_E);
          1: send_key(KEY_UNUSED_D);
          2: send_key(tac_pkg::KEY_CONFIG);
          3: send_key(tac_pkg::KEY_TOGGLE);
          4: send_key(tac_pkg::KEY_STOP);
          5: send_key(tac_pkg::KEY_OK);
          default: send_key(tac_pkg::KEY_ZERO + 8'($urandom_range(9)));
        endcase
        sent++;
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tuser = 1'b0;
    in_tdata = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    beat_typed = 1'b0;
    beat_want = NO_WANT;
    m_mode = tac_pkg::MODE_MAIN;
    m_enabled = 1'b1;
    m_temp = 8'd0;
    m_thresh = tac_pkg::THRESH_RESET;
    m_entry = 8'd0;
    m_count = 2'd0;
    m_span = tac_pkg::SPAN_RESET;
    errors = 0;
    checked = 0;
    beats = 0;
    alarm_beats = 0;
    spans_used = 1;
    cycles = 0;
    in_idle_pct = 30;
    out_idle_pct = 79;
    want_hold = 1'b0;
    hold_done = 1'b0;
    last_smp = 10'd0;

    directed = '{
      '{1'b0, 10'd0,    8'd0,                     1'b1, EXP_RESET},
      '{1'b0, 10'd1023, 8'd0,                     1'b1, EXP_FULL},
      '{1'b1, 10'd0,    tac_pkg::KEY_CONFIG,      1'b0, NO_WANT},
      '{1'b1, 10'd0,    tac_pkg::KEY_STOP,        1'b0, NO_WANT},
      '{1'b1, 10'd0,    tac_pkg::KEY_TOGGLE,      1'b0, NO_WANT},
      '{1'b1, 10'd0,    tac_pkg::KEY_STOP,        1'b0, NO_WANT},
      '{1'b1, 10'd0,    tac_pkg::KEY_CONFIG,      1'b0, NO_WANT},
      '{1'b1, 10'd0,    tac_pkg::KEY_NINE,        1'b0, NO_WANT},
      '{1'b1, 10'd0,    tac_pkg::KEY_NINE,        1'b0, NO_WANT},
      '{1'b1, 10'd0,    tac_pkg::KEY_NINE,        1'b0, NO_WANT},
      '{1'b1, 10'd0,    tac_pkg::KEY_ZERO + 8'd7, 1'b0, NO_WANT},
      '{1'b1, 10'd0,    tac_pkg::KEY_OK,          1'b0, NO_WANT},
      '{1'b1, 10'd0,    tac_pkg::KEY_CONFIG,      1'b0, NO_WANT},
      '{1'b1, 10'd0,    tac_pkg::KEY_OK,          1'b0, NO_WANT},
      '{1'b1, 10'd0,    tac_pkg::KEY_CONFIG,      1'b0, NO_WANT},
      '{1'b1, 10'd0,    tac_pkg::KEY_ZERO + 8'd1, 1'b0, NO_WANT},
      '{1'b1, 10'd0,    tac_pkg::KEY_ZERO + 8'd2, 1'b0, NO_WANT},
      '{1'b1, 10'd0,    tac_pkg::KEY_ZERO,        1'b0, NO_WANT},
      '{1'b1, 10'd0,    tac_pkg::KEY_OK,          1'b0, NO_WANT},
      '{1'b1, 10'd0,    tac_pkg::KEY_CONFIG,      1'b0, NO_WANT},
      '{1'b1, 10'd0,    KEY_UNUSED_E,             1'b0, NO_WANT},
      '{1'b1, 10'd0,    tac_pkg::KEY_CONFIG,      1'b0, NO_WANT},
      '{1'b0, 10'd0,    8'd255,                   1'b0, NO_WANT},
      '{1'b1, 10'd1023, tac_pkg::KEY_TOGGLE,      1'b0, NO_WANT},
      '{1'b1, 10'd0,    tac_pkg::KEY_CONFIG,      1'b0, NO_WANT},
      '{1'b1, 10'd0,    tac_pkg::KEY_ZERO + 8'd7, 1'b0, NO_WANT},
      '{1'b0, 10'd1023, 8'd0,                     1'b0, NO_WANT},
      '{1'b1, 10'd0,    tac_pkg::KEY_STOP,        1'b0, NO_WANT}
    };

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < NDIR; i++) begin
      send_beat(directed[i].act, directed[i].smp, directed[i].key, directed[i].typed,
                directed[i].want);
    end

    for (int p = 0; p < PHASES; p++) begin
      drain();
      case (p)
        0: write_span(8'd255);
        1: write_span(8'd1);
        2: write_span(8'd0);
        4: write_span(tac_pkg::SPAN_RESET);
        default: write_span(8'($urandom_range(1, 255)));
      endcase
      case (p / 2)
        0: begin
          in_idle_pct = 30;
          out_idle_pct = 79;
        end
        1: begin
          in_idle_pct = 79;
          out_idle_pct = 30;
        end
        default: begin
          in_idle_pct = 0;
          out_idle_pct = 0;
        end
      endcase
      if (p == 5) begin
        want_hold = 1'b1;
      end
      if (p == 3) begin
        send_random(PER_RUN / 2);
        drain();
        send_random(PER_RUN / 2);
      end else begin
        send_random(PER_RUN);
      end
    end

    drain();
    repeat (10) @(posedge clk);
    if (status_q.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, status_q.size());
      errors++;
    end
    $display("Sent %0d beats over %0d span settings, checked %0d results.",
             beats, spans_used, checked);
    $display("%0d results carried the buzzer request, %0d mismatches.", alarm_beats, errors);
    if (errors == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
design/tac_pkg.sv
design/tac_step.sv
design/temperature_alarm_controller_unit.sv
verif/testbench.sv
